>>> design/qce_pkg.sv
package qce_pkg;

  // Token event codes carried in the op field.
  localparam logic [2:0] OP_CMD_NAME   = 3'd0;
  localparam logic [2:0] OP_PARAM_NAME = 3'd1;
  localparam logic [2:0] OP_VALUE_GO   = 3'd2;
  localparam logic [2:0] OP_VALUE_BYTE = 3'd3;
  localparam logic [2:0] OP_NEXT_ROW   = 3'd4;
  localparam logic [2:0] OP_FINISH     = 3'd5;

  // Status codes reported with every result.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_NAME   = 3'd1;
  localparam logic [2:0] ST_NULL_VALUE = 3'd2;
  localparam logic [2:0] ST_EMPTY_ROW  = 3'd3;
  localparam logic [2:0] ST_TRAIL_ROW  = 3'd4;

  // Characters of the command syntax.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       first;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
  } result_t;

  // Up to two results for one item; the status is common to both.
  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic       two;
    logic [2:0] status;
  } pair_t;

  // Escape letter for a value byte, or zero when it passes through.
  function automatic logic [7:0] escape_code(input logic [7:0] c);
    logic [7:0] e;
    case (c)
      8'h5C:   e = CH_BSL;
      8'h2F:   e = CH_SLASH;
      8'h20:   e = 8'h73; // s
      8'h7C:   e = 8'h70; // p
      8'h07:   e = 8'h61; // a
      8'h08:   e = 8'h62; // b
      8'h0C:   e = 8'h66; // f
      8'h0A:   e = 8'h6E; // n
      8'h0D:   e = 8'h72; // r
      8'h09:   e = 8'h74; // t
      8'h0B:   e = 8'h76; // v
      default: e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

>>> design/qce_encoder.sv
module qce_encoder (
  input  logic           clk,
  input  logic           rst_n,
  input  qce_pkg::item_t item,
  input  logic           commit,
  output qce_pkg::pair_t pair
);
  import qce_pkg::*;

  logic       on_first_row_r, on_first_row_nxt;
  logic       row_has_param_r, row_has_param_nxt;
  logic       bad_name;
  logic [7:0] esc;

  assign bad_name = item.data inside {CH_NUL, CH_SPACE, CH_EQ, CH_PIPE};
  assign esc      = escape_code(item.data);

  always_comb begin
    pair              = '0;
    pair.status       = ST_OK;
    on_first_row_nxt  = on_first_row_r;
    row_has_param_nxt = row_has_param_r;
    case (item.op)
      OP_CMD_NAME: begin
        if (bad_name) begin
          pair.status = ST_BAD_NAME;
        end else begin
          pair.res0 = '{data: item.data, byte_valid: 1'b1};
          if (item.first) begin
            on_first_row_nxt  = 1'b1;
            row_has_param_nxt = 1'b0;
          end
        end
      end
      OP_PARAM_NAME: begin
        if (bad_name) begin
          pair.status = ST_BAD_NAME;
        end else if (item.first && (on_first_row_r || row_has_param_r)) begin
          pair.res0         = '{data: CH_SPACE, byte_valid: 1'b1};
          pair.res1         = '{data: item.data, byte_valid: 1'b1};
          pair.two          = 1'b1;
          row_has_param_nxt = 1'b1;
        end else begin
          pair.res0 = '{data: item.data, byte_valid: 1'b1};
          if (item.first) begin
            row_has_param_nxt = 1'b1;
          end
        end
      end
      OP_VALUE_GO: begin
        pair.res0 = '{data: CH_EQ, byte_valid: 1'b1};
      end
      OP_VALUE_BYTE: begin
        if (item.data == CH_NUL) begin
          pair.status = ST_NULL_VALUE;
        end else if (esc != 8'h00) begin
          pair.res0 = '{data: CH_BSL, byte_valid: 1'b1};
          pair.res1 = '{data: esc, byte_valid: 1'b1};
          pair.two  = 1'b1;
        end else begin
          pair.res0 = '{data: item.data, byte_valid: 1'b1};
        end
      end
      OP_NEXT_ROW: begin
        if (!row_has_param_r) begin
          pair.status = ST_EMPTY_ROW;
        end else begin
          pair.res0         = '{data: CH_PIPE, byte_valid: 1'b1};
          on_first_row_nxt  = 1'b0;
          row_has_param_nxt = 1'b0;
        end
      end
      OP_FINISH: begin
        if (!on_first_row_r && !row_has_param_r) begin
          pair.status = ST_TRAIL_ROW;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_first_row_r  <= 1'b1;
      row_has_param_r <= 1'b0;
    end else if (commit) begin
      on_first_row_r  <= on_first_row_nxt;
      row_has_param_r <= row_has_param_nxt;
    end
  end

endmodule

>>> design/qce_out_stage.sv
module qce_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load_valid,
  input  qce_pkg::pair_t load_pair,
  output logic           load_ok,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_byte_valid,
  output logic [2:0]     out_status,
  output logic           out_last
);
  import qce_pkg::*;

  pair_t   pair_r;
  logic    valid_r, valid_nxt;
  logic    sel_r, sel_nxt;
  result_t cur;
  logic    take;
  logic    done;

  assign cur            = sel_r ? pair_r.res1 : pair_r.res0;
  assign out_valid      = valid_r;
  assign out_byte       = cur.data;
  assign out_byte_valid = cur.byte_valid;
  assign out_status     = pair_r.status;
  assign out_last       = !pair_r.two || sel_r;

  assign take    = valid_r && !out_stall;
  assign done    = take && out_last;
  assign load_ok = !valid_r || done;

  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    if (load_ok) begin
      valid_nxt = load_valid;
      sel_nxt   = 1'b0;
    end else if (take) begin
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && load_valid) begin
      pair_r <= load_pair;
    end
  end

  a_sel_only_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (valid_r && pair_r.two))
    else $error("second result selected without a two-result item");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_last) |=> (valid_r && sel_r && $stable(out_status)))
    else $error("second result of an item did not follow the first");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_byte_valid) |-> (out_byte == 8'h00))
    else $error("result without a byte carries a nonzero byte");

endmodule

>>> design/query_command_escaper.sv
// Query command escaper: turns a stream of token items (command name bytes,
// parameter name bytes, value starts, value bytes, next-row and finish events)
// into the bytes of a text query command, one byte per result item, and flags
// bad name characters, null value bytes, empty rows and a trailing empty row.
// Each input item passes through an input register and then a result register,
// and its first result is offered once the result register has loaded it. A
// parameter name byte that needs a leading space and a value byte that is
// escaped give two results, where other items give one (a byte, or a
// status-only result); the result register presents one byte per cycle while
// out_stall is low. It is refilled in the same cycle that its last result is
// taken, so single-result items flow at one per cycle while the output side
// keeps up.
module query_command_escaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [7:0] in_byte,
  input  logic       in_first,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic [2:0] out_status,
  output logic       out_last
);
  import qce_pkg::*;

  // Input register: holds the accepted item until the result register can
  // take the results that it causes.
  item_t item_r;
  logic  item_valid_r;
  pair_t pair;
  logic  load_ok;
  logic  commit;

  // The item moves on, and the row state is updated, when the result
  // register takes its results.
  assign commit   = item_valid_r && load_ok;
  assign in_stall = item_valid_r && !load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= '{op: in_op, data: in_byte, first: in_first};
    end
  end

  // Decoding and escaping, together with the two row flags.
  qce_encoder u_encoder (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item_r),
    .commit (commit),
    .pair   (pair)
  );

  // Result register: presents the first and, where there is one, the second
  // result of an item, then takes the next item's results.
  qce_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_valid     (item_valid_r),
    .load_pair      (pair),
    .load_ok        (load_ok),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

>>> verif/tb_query_command_escaper.sv
`timescale 1ns / 100ps

module tb_query_command_escaper;
  import qce_pkg::*;

  // Control characters among the value bytes that cannot pass through unchanged.
  localparam logic [7:0] ESC_BEL_CH = 8'h07;
  localparam logic [7:0] ESC_BS_CH  = 8'h08;
  localparam logic [7:0] ESC_TAB_CH = 8'h09;
  localparam logic [7:0] ESC_LF_CH  = 8'h0A;
  localparam logic [7:0] ESC_VT_CH  = 8'h0B;
  localparam logic [7:0] ESC_FF_CH  = 8'h0C;
  localparam logic [7:0] ESC_CR_CH  = 8'h0D;

  // Opcodes the block does not use; they are answered with a plain OK.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // Stimulus sizing and the long receiver hold-off.
  localparam int TOKEN_TARGET = 1050;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_GAP      = 13;
  localparam int DRAIN_CYCLES = 10;

  // The escapable characters, used to bias value bytes towards escapes.
  localparam logic [7:0] ESCAPABLE [11] = '{
    CH_BSL, CH_SLASH, CH_SPACE, CH_PIPE, ESC_BEL_CH, ESC_BS_CH,
    ESC_FF_CH, ESC_LF_CH, ESC_CR_CH, ESC_TAB_CH, ESC_VT_CH
  };

  // Tracks the two row flags of the command being built and keeps the queue
  // of bytes (and status-only results) that the block should emit next.
  class escape_scoreboard;
    typedef struct {
      logic [7:0] chr;
      logic       has_byte;
      logic [2:0] status;
      logic       last;
    } emitted_t;

    emitted_t expected_bytes[$];
    bit       on_first_row;
    bit       row_has_param;
    int       errors;
    int       items_seen;
    int       results_checked;
    int       escapes;
    int       flagged;

    function new();
      on_first_row  = 1'b1;
      row_has_param = 1'b0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void push(logic [7:0] chr, logic has_byte, logic [2:0] status, logic last);
      emitted_t e;
      e.chr      = has_byte ? chr : 8'h00;
      e.has_byte = has_byte;
      e.status   = status;
      e.last     = last;
      expected_bytes = {expected_bytes, e};
      if (status != ST_OK && last) flagged++;
    endfunction

    function bit is_bad_name(logic [7:0] c);
      return c == CH_NUL || c == CH_SPACE || c == CH_EQ || c == CH_PIPE;
    endfunction

    function logic [7:0] escape_letter(logic [7:0] c);
      case (c)
        CH_BSL:     return CH_BSL;
        CH_SLASH:   return CH_SLASH;
        CH_SPACE:   return "s";
        CH_PIPE:    return "p";
        ESC_BEL_CH: return "a";
        ESC_BS_CH:  return "b";
        ESC_FF_CH:  return "f";
        ESC_LF_CH:  return "n";
        ESC_CR_CH:  return "r";
        ESC_TAB_CH: return "t";
        ESC_VT_CH:  return "v";
        default:    return 8'h00;
      endcase
    endfunction

    // Works out what one accepted token item produces and updates the flags.
    function void predict_token(logic [2:0] op, logic [7:0] c, logic first);
      logic [7:0] letter;
      items_seen++;
      case (op)
        OP_CMD_NAME: begin
          if (is_bad_name(c)) begin
            push(8'h00, 1'b0, ST_BAD_NAME, 1'b1);
          end else begin
            if (first) begin
              on_first_row  = 1'b1;
              row_has_param = 1'b0;
            end
            push(c, 1'b1, ST_OK, 1'b1);
          end
        end
        OP_PARAM_NAME: begin
          if (is_bad_name(c)) begin
            push(8'h00, 1'b0, ST_BAD_NAME, 1'b1);
          end else begin
            if (first && (on_first_row || row_has_param))
              push(CH_SPACE, 1'b1, ST_OK, 1'b0);
            if (first) row_has_param = 1'b1;
            push(c, 1'b1, ST_OK, 1'b1);
          end
        end
        OP_VALUE_GO: push(CH_EQ, 1'b1, ST_OK, 1'b1);
        OP_VALUE_BYTE: begin
          letter = escape_letter(c);
          if (c == CH_NUL) begin
            push(8'h00, 1'b0, ST_NULL_VALUE, 1'b1);
          end else if (letter != 8'h00) begin
            escapes++;
            push(CH_BSL, 1'b1, ST_OK, 1'b0);
            push(letter, 1'b1, ST_OK, 1'b1);
          end else begin
            push(c, 1'b1, ST_OK, 1'b1);
          end
        end
        OP_NEXT_ROW: begin
          if (!row_has_param) begin
            push(8'h00, 1'b0, ST_EMPTY_ROW, 1'b1);
          end else begin
            on_first_row  = 1'b0;
            row_has_param = 1'b0;
            push(CH_PIPE, 1'b1, ST_OK, 1'b1);
          end
        end
        OP_FINISH: begin
          if (!on_first_row && !row_has_param) push(8'h00, 1'b0, ST_TRAIL_ROW, 1'b1);
          else push(8'h00, 1'b0, ST_OK, 1'b1);
        end
        default: push(8'h00, 1'b0, ST_OK, 1'b1);
      endcase
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [7:0] chr, logic has_byte, logic [2:0] status, logic last);
      emitted_t want;
      results_checked++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("result with nothing pending (byte %02h valid %0b status %0d)",
                         chr, has_byte, status));
        return;
      end
      want = expected_bytes.pop_front();
      if (chr !== want.chr)
        report($sformatf("out_byte %02h, expected %02h", chr, want.chr));
      if (has_byte !== want.has_byte)
        report($sformatf("out_byte_valid %0b, expected %0b", has_byte, want.has_byte));
      if (status !== want.status)
        report($sformatf("out_status %0d, expected %0d", status, want.status));
      if (last !== want.last)
        report($sformatf("out_last %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_op;
  logic [7:0] in_byte;
  logic       in_first;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic [2:0] out_status;
  logic       out_last;

  // Set for a long stretch by its own process so that the result side backs
  // up all the way to the input.
  logic rx_hold = 1'b0;

  // Each side alternates between stretches with random gaps and bursts with
  // none at all.
  bit tx_burst;
  bit rx_burst;
  int token_count;

  escape_scoreboard sb = new();

  query_command_escaper DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_byte        (in_byte),
    .in_first       (in_first),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // A character for a command or parameter name. Mostly ordinary identifier
  // characters, but now and then any byte at all, so that bad name
  // characters turn up inside otherwise well-formed commands.
  function automatic logic [7:0] name_char();
    case ($urandom_range(0, 11))
      0:       return 8'($urandom_range(0, 255));
      1, 2:    return 8'($urandom_range(48, 57));
      3:       return 8'($urandom_range(65, 90));
      4:       return 8'h5F;
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  // A value character, biased towards the escapable set with the odd null.
  function automatic logic [7:0] value_char();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return CH_NUL;
    if (pick < 8) return ESCAPABLE[$urandom_range(0, 10)];
    return 8'($urandom_range(1, 255));
  endfunction

  // Offers one item and returns at the edge that accepts it. The task is
  // always entered just after a rising edge, and each path assigns in_valid
  // only once per time step, so a back-to-back item keeps valid high.
  task automatic send_item(logic [2:0] op, logic [7:0] chr, logic first);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_byte  <= chr;
    in_first <= first;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.predict_token(op, chr, first);
    // Spare opcodes only get a plain OK result from the block, so they do not count
    // towards the amount of stimulus.
    if (op != OP_SPARE_A && op != OP_SPARE_B) token_count++;
  endtask

  // Takes one result, after a random hold-off and any long hold in force.
  task automatic take_result();
    int gap;
    if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
    gap = draw_gap(rx_burst);
    if (gap > 0 || rx_hold) begin
      out_stall <= 1'b1;
      repeat (gap) @(posedge clk);
      while (rx_hold) @(posedge clk);
    end
    out_stall <= 1'b0;
    do @(posedge clk); while (out_valid !== 1'b1);
    sb.check_result(out_byte, out_byte_valid, out_status, out_last);
  endtask

  // A well-formed command with random content: a name, one to three rows of
  // parameters with optional values, separators between rows and a closing
  // finish. A row is left empty now and then, which gives the empty row and
  // trailing empty row cases in a realistic setting.
  task automatic send_command();
    int n_name;
    int n_rows;
    int n_params;
    int n_chars;
    n_name = $urandom_range(1, 6);
    for (int i = 0; i < n_name; i++) send_item(OP_CMD_NAME, name_char(), i == 0);
    n_rows = $urandom_range(1, 3);
    for (int r = 0; r < n_rows; r++) begin
      if (r > 0) send_item(OP_NEXT_ROW, 8'($urandom), 1'($urandom));
      n_params = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      for (int p = 0; p < n_params; p++) begin
        n_chars = $urandom_range(1, 5);
        for (int i = 0; i < n_chars; i++) send_item(OP_PARAM_NAME, name_char(), i == 0);
        if ($urandom_range(0, 3) != 0) begin
          send_item(OP_VALUE_GO, 8'($urandom), 1'($urandom));
          n_chars = $urandom_range(0, 6);
          for (int i = 0; i < n_chars; i++)
            send_item(OP_VALUE_BYTE, value_char(), 1'($urandom));
        end
      end
    end
    send_item(OP_FINISH, 8'($urandom), 1'($urandom));
  endtask

  // Main sequence: reset, a directed pass over the corner cases, random
  // commands mixed with noise, then the drain and the verdict.
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_op     = OP_CMD_NAME;
    in_byte   = 8'h00;
    in_first  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The command name opens a command, then bad name
    // characters are flagged, a separator with no parameter is an empty row
    // and a finish on the first row is fine.
    send_item(OP_CMD_NAME, "c", 1'b1);
    send_item(OP_CMD_NAME, 8'hFF, 1'b0);
    send_item(OP_CMD_NAME, CH_NUL, 1'b1);
    send_item(OP_CMD_NAME, CH_PIPE, 1'b0);
    send_item(OP_NEXT_ROW, 8'h00, 1'b0);
    send_item(OP_FINISH, 8'hFF, 1'b1);
    // The first parameter on the first row gets a leading space.
    send_item(OP_PARAM_NAME, "k", 1'b1);
    send_item(OP_PARAM_NAME, CH_EQ, 1'b1);
    send_item(OP_PARAM_NAME, CH_SPACE, 1'b0);
    send_item(OP_VALUE_GO, 8'h00, 1'b0);
    // A null value byte, a spread of escapes and a byte that passes through.
    send_item(OP_VALUE_BYTE, CH_NUL, 1'b0);
    send_item(OP_VALUE_BYTE, CH_BSL, 1'b0);
    send_item(OP_VALUE_BYTE, CH_SLASH, 1'b1);
    send_item(OP_VALUE_BYTE, CH_SPACE, 1'b0);
    send_item(OP_VALUE_BYTE, CH_PIPE, 1'b0);
    send_item(OP_VALUE_BYTE, ESC_BEL_CH, 1'b0);
    send_item(OP_VALUE_BYTE, ESC_VT_CH, 1'b0);
    send_item(OP_VALUE_BYTE, 8'hFF, 1'b0);
    // A separator, then a finish on an empty second row is a trailing row.
    send_item(OP_NEXT_ROW, 8'hFF, 1'b1);
    send_item(OP_FINISH, 8'h00, 1'b0);
    // On a later row the first parameter has no space, the second has one.
    send_item(OP_PARAM_NAME, "x", 1'b1);
    send_item(OP_PARAM_NAME, "y", 1'b1);
    send_item(OP_SPARE_A, 8'hA5, 1'b1);
    send_item(OP_SPARE_B, 8'h5A, 1'b0);
    send_item(OP_FINISH, 8'h00, 1'b1);

    // Random part: mostly whole commands, with about one pick in ten a single item
    // drawn from the full range of every field.
    while (token_count < TOKEN_TARGET) begin
      if ($urandom_range(0, 9) == 0)
        send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
      else
        send_command();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d token items and %0d result items, of which %0d escapes.",
             sb.items_seen, sb.results_checked, sb.escapes);
    $display("Items flagged with a non-OK status: %0d; mismatches: %0d.",
             sb.flagged, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_query_command_escaper: PASS");
    end else begin
      $display("tb_query_command_escaper: FAIL");
    end
    $finish;
  end

  // The result side runs for the whole test once reset has been released.
  initial begin
    wait (rst_n === 1'b1);
    forever take_result();
  end

  // Once a few hundred items have gone in, the receiver holds off for a long
  // stretch while the sender keeps offering, so that both registers fill and
  // the block has to stall its input.
  initial begin
    wait (rst_n === 1'b1);
    while (sb.items_seen < HOLD_AFTER) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog: gives up with a failure if the run has not finished within the delay below.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results still pending.", sb.pending());
    $display("tb_query_command_escaper: FAIL");
    $finish;
  end

endmodule

>>> sim.f
design/qce_pkg.sv
design/qce_encoder.sv
design/qce_out_stage.sv
design/query_command_escaper.sv
verif/tb_query_command_escaper.sv
